[sv/round_rest_interval_timer_defines.svh]
// Assertion macros for the round and rest interval timer.
// Needs a clk_i clock and an active-low rst_ni reset in the including module.
`ifndef ROUND_REST_INTERVAL_TIMER_DEFINES_SVH
`define ROUND_REST_INTERVAL_TIMER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define RRIT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrit same-cycle check failed");

// Next-cycle implication, checked out of reset
`define RRIT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrit next-cycle check failed");

`endif

[sv/rrit_pkg.sv]
// Shared types and constants for the round and rest interval timer.
// No dependencies; imported by every module of the block.
package rrit_pkg;

  // Widths
  localparam int CfgW   = 18;
  localparam int TimeW  = 19;
  localparam int CalcW  = 20;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  // Register indexes (word address paddr[4:2])
  localparam logic [2:0] REG_LEAD_IN     = 3'd0;
  localparam logic [2:0] REG_SHORT_ROUND = 3'd1;
  localparam logic [2:0] REG_LONG_ROUND  = 3'd2;
  localparam logic [2:0] REG_SHORT_REST  = 3'd3;
  localparam logic [2:0] REG_LONG_REST   = 3'd4;
  localparam logic [2:0] REG_WARNING     = 3'd5;

  // Register reset values, ms
  localparam logic [CfgW-1:0] LEAD_IN_RST     = 18'd5000;
  localparam logic [CfgW-1:0] SHORT_ROUND_RST = 18'd120000;
  localparam logic [CfgW-1:0] LONG_ROUND_RST  = 18'd180000;
  localparam logic [CfgW-1:0] SHORT_REST_RST  = 18'd30000;
  localparam logic [CfgW-1:0] LONG_REST_RST   = 18'd60000;
  localparam logic [CfgW-1:0] WARNING_RST     = 18'd30000;

  // Beep timing, ms; every beep goes silent BeepGap before its end
  localparam int BeepGap       = 20;
  localparam int StartBeepLen  = 500;
  localparam int WarnBeepLen   = 150;
  localparam int WarnBeepPitch = 200;
  localparam int WarnBeepCount = 5;
  localparam int FinalBeepOfs  = 1000;
  localparam int FinalBeepLen  = 300;
  localparam int RestBeepLen   = 1500;

  typedef enum logic [1:0] {
    LAMP_NONE   = 2'd0,
    LAMP_RED    = 2'd1,
    LAMP_GREEN  = 2'd2,
    LAMP_ORANGE = 2'd3
  } lamp_e;

  typedef enum logic [1:0] {
    PHASE_OFF     = 2'd0,
    PHASE_LEAD_IN = 2'd1,
    PHASE_CYCLE   = 2'd2,
    PHASE_SPARE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [CfgW-1:0] lead_in_ms;
    logic [CfgW-1:0] short_round_ms;
    logic [CfgW-1:0] long_round_ms;
    logic [CfgW-1:0] short_rest_ms;
    logic [CfgW-1:0] long_rest_ms;
    logic [CfgW-1:0] warning_ms;
  } cfg_t;

  typedef struct packed {
    logic power_on;
    logic round_long;
    logic rest_long;
  } item_t;

  typedef struct packed {
    logic             buzzer;
    lamp_e            lamp;
    logic             power_led;
    phase_e           phase;
    logic [TimeW-1:0] elapsed_ms;
  } result_t;

endpackage

[sv/round_rest_interval_timer.sv]
// Round and rest interval timer: one millisecond tick in, one lamp/buzzer result out.
// Timing and lamp rules sit in a single-pass evaluator between an input and a result register.
// Depends on rrit_pkg, rrit_regs and rrit_core.
//
// Usage:
//   Each input transaction is one millisecond tick with the power switch and the
//   round/rest length selectors. Each tick yields exactly one result transaction
//   with the latched buzzer and lamp, power indicator, phase and the elapsed time
//   evaluated on that tick. Both channels use valid/stall.
//   An accepted tick sits in the input register, is evaluated and lands in the
//   result register, from which the result transaction is taken out. One tick
//   per cycle is sustained while the receiver does not stall; the combinational
//   path is the selector check, the round/rest boundary compares and the beep
//   window compares.
//   While the receiver stalls, the result holds, the input register still
//   fills once, and then in_stall_o rises until the result is taken.
//   Reset empties both registers, loads the register defaults and puts the
//   timer asleep at t=0 in lead-in. The user must write the registers over APB
//   only while no tick is in flight; the block itself does not enforce it.
module round_rest_interval_timer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rrit_pkg::AddrW-1:0] paddr,
  input  logic [rrit_pkg::DataW-1:0] pwdata,
  output logic [rrit_pkg::DataW-1:0] prdata,
  output logic                       pready,
  // Tick channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       power_on_i,
  input  logic                       round_long_i,
  input  logic                       rest_long_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       buzzer_o,
  output logic [1:0]                 lamp_o,
  output logic                       power_led_o,
  output logic [1:0]                 phase_o,
  output logic [rrit_pkg::TimeW-1:0] elapsed_ms_o
);
  import rrit_pkg::*;

  cfg_t    cfg;
  item_t   in_item_q, in_item_d;
  logic    in_valid_q, in_valid_d;
  result_t res, res_q;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic    in_load;

  rrit_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move the held tick into the result register when that is free
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    in_item_d  = in_item_q;
    if (in_load) begin
      in_valid_d          = in_valid_i;
      in_item_d.power_on   = power_on_i;
      in_item_d.round_long = round_long_i;
      in_item_d.rest_long  = rest_long_i;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  rrit_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (res)
  );

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    in_item_q <= in_item_d;
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign buzzer_o     = res_q.buzzer;
  assign lamp_o       = res_q.lamp;
  assign power_led_o  = res_q.power_led;
  assign phase_o      = res_q.phase;
  assign elapsed_ms_o = res_q.elapsed_ms;

endmodule

[sv/rrit_regs.sv]
// APB configuration registers of the round and rest interval timer.
// Depends on rrit_pkg.
module rrit_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [rrit_pkg::AddrW-1:0] paddr,
  input  logic [rrit_pkg::DataW-1:0] pwdata,
  output logic [rrit_pkg::DataW-1:0] prdata,
  output logic                     pready,
  output rrit_pkg::cfg_t           cfg_o
);
  import rrit_pkg::*;

  cfg_t            cfg_q, cfg_d;
  logic [2:0]      word_idx;
  logic            wr_en;
  logic [CfgW-1:0] wr_val;
  logic [CfgW-1:0] rd_val;

  assign pready   = 1'b1;
  assign word_idx = paddr[AddrW-1:2];
  assign wr_en    = psel && penable && pwrite;
  assign wr_val   = pwdata[CfgW-1:0];

  // Decode the write transaction
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (word_idx)
        REG_LEAD_IN:     cfg_d.lead_in_ms     = wr_val;
        REG_SHORT_ROUND: cfg_d.short_round_ms = wr_val;
        REG_LONG_ROUND:  cfg_d.long_round_ms  = wr_val;
        REG_SHORT_REST:  cfg_d.short_rest_ms  = wr_val;
        REG_LONG_REST:   cfg_d.long_rest_ms   = wr_val;
        REG_WARNING:     cfg_d.warning_ms     = wr_val;
        default: ;
      endcase
    end
  end

  // Decode the read transaction
  always_comb begin
    unique case (word_idx)
      REG_LEAD_IN:     rd_val = cfg_q.lead_in_ms;
      REG_SHORT_ROUND: rd_val = cfg_q.short_round_ms;
      REG_LONG_ROUND:  rd_val = cfg_q.long_round_ms;
      REG_SHORT_REST:  rd_val = cfg_q.short_rest_ms;
      REG_LONG_REST:   rd_val = cfg_q.long_rest_ms;
      REG_WARNING:     rd_val = cfg_q.warning_ms;
      default:         rd_val = '0;
    endcase
  end

  assign prdata = {{(DataW-CfgW){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lead_in_ms     <= LEAD_IN_RST;
      cfg_q.short_round_ms <= SHORT_ROUND_RST;
      cfg_q.long_round_ms  <= LONG_ROUND_RST;
      cfg_q.short_rest_ms  <= SHORT_REST_RST;
      cfg_q.long_rest_ms   <= LONG_REST_RST;
      cfg_q.warning_ms     <= WARNING_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[sv/rrit_core.sv]
// Timer state and per-tick phase evaluation of the round and rest interval timer.
// Depends on rrit_pkg and round_rest_interval_timer_defines.svh.
`include "round_rest_interval_timer_defines.svh"

module rrit_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrit_pkg::cfg_t    cfg_i,
  input  logic              step_i,
  input  rrit_pkg::item_t   item_i,
  output rrit_pkg::result_t result_o
);
  import rrit_pkg::*;

  logic [TimeW-1:0] elapsed_q, elapsed_d;
  logic             in_lead_q, in_lead_d;
  logic             awake_q, awake_d;
  logic             last_round_q, last_round_d;
  logic             last_rest_q, last_rest_d;
  logic             buzzer_q, buzzer_d;
  lamp_e            lamp_q, lamp_d;

  logic             last_r, last_s, sel_change;
  logic [TimeW-1:0] t;
  logic [CfgW-1:0]  r, s, w, base;
  logic [CalcW-1:0] t_x, r_x, w_x, rs_x, d, e, lead_x;
  logic             lead;

  // Pick the active lengths and detect a selector change
  always_comb begin
    last_r     = awake_q ? last_round_q : item_i.round_long;
    last_s     = awake_q ? last_rest_q  : item_i.rest_long;
    sel_change = (item_i.round_long != last_r) || (item_i.rest_long != last_s);
    t          = sel_change ? '0 : elapsed_q;
    lead       = sel_change ? 1'b1 : in_lead_q;
    r          = item_i.round_long ? cfg_i.long_round_ms : cfg_i.short_round_ms;
    s          = item_i.rest_long  ? cfg_i.long_rest_ms  : cfg_i.short_rest_ms;
    w          = cfg_i.warning_ms;
    base       = r - w;
    t_x        = CalcW'(t);
    r_x        = CalcW'(r);
    w_x        = CalcW'(w);
    lead_x     = CalcW'(cfg_i.lead_in_ms);
    rs_x       = r_x + CalcW'(s);
    d          = t_x - CalcW'(base);
    e          = t_x - r_x;
  end

  // Evaluate the tick and work out the next state
  always_comb begin
    elapsed_d    = elapsed_q;
    in_lead_d    = in_lead_q;
    awake_d      = awake_q;
    last_round_d = last_round_q;
    last_rest_d  = last_rest_q;
    buzzer_d     = buzzer_q;
    lamp_d       = lamp_q;
    result_o     = '0;

    if (!item_i.power_on) begin
      // Power off: drop everything back to reset
      elapsed_d    = '0;
      in_lead_d    = 1'b1;
      awake_d      = 1'b0;
      last_round_d = 1'b0;
      last_rest_d  = 1'b0;
      buzzer_d     = 1'b0;
      lamp_d       = LAMP_NONE;
      result_o.phase = PHASE_OFF;
      result_o.lamp  = LAMP_NONE;
    end else begin
      awake_d      = 1'b1;
      last_round_d = item_i.round_long;
      last_rest_d  = item_i.rest_long;
      in_lead_d    = lead;
      if (sel_change) begin
        buzzer_d = 1'b0;
        lamp_d   = LAMP_NONE;
      end

      if (lead) begin
        result_o.phase = PHASE_LEAD_IN;
        if (t_x <= lead_x) begin
          lamp_d = LAMP_RED;
        end
        if (t_x >= lead_x) begin
          in_lead_d = 1'b0;
          elapsed_d = '0;
        end else begin
          elapsed_d = t + TimeW'(1);
        end
      end else begin
        result_o.phase = PHASE_CYCLE;
        // Round part, with the warning span at its end
        if (t_x <= r_x) begin
          if ((w_x <= r_x) && (t_x >= r_x - w_x)) begin
            for (int k = 0; k < WarnBeepCount; k++) begin
              if ((d >= CalcW'(k * WarnBeepPitch)) &&
                  (d <= CalcW'(k * WarnBeepPitch + WarnBeepLen))) begin
                buzzer_d = (d < CalcW'(k * WarnBeepPitch + WarnBeepLen - BeepGap));
              end
            end
            if ((d >= CalcW'(FinalBeepOfs)) &&
                (d <= CalcW'(FinalBeepOfs + FinalBeepLen))) begin
              buzzer_d = (d < CalcW'(FinalBeepOfs + FinalBeepLen - BeepGap));
            end
            lamp_d = LAMP_ORANGE;
          end else begin
            if (t_x <= CalcW'(StartBeepLen)) begin
              buzzer_d = (t_x < CalcW'(StartBeepLen - BeepGap));
            end
            lamp_d = LAMP_GREEN;
          end
        end
        // Rest part wins at the boundary
        if ((t_x >= r_x) && (t_x <= rs_x)) begin
          if (e <= CalcW'(RestBeepLen)) begin
            buzzer_d = (e < CalcW'(RestBeepLen - BeepGap));
          end
          lamp_d = LAMP_RED;
        end
        if (t_x >= rs_x) begin
          elapsed_d = '0;
        end else begin
          elapsed_d = t + TimeW'(1);
        end
      end

      result_o.buzzer     = buzzer_d;
      result_o.lamp       = lamp_d;
      result_o.power_led  = 1'b1;
      result_o.elapsed_ms = t;
    end
  end

  // Hold the timer state; advance only on a tick that moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q    <= '0;
      in_lead_q    <= 1'b1;
      awake_q      <= 1'b0;
      last_round_q <= 1'b0;
      last_rest_q  <= 1'b0;
      buzzer_q     <= 1'b0;
      lamp_q       <= LAMP_NONE;
    end else if (step_i) begin
      elapsed_q    <= elapsed_d;
      in_lead_q    <= in_lead_d;
      awake_q      <= awake_d;
      last_round_q <= last_round_d;
      last_rest_q  <= last_rest_d;
      buzzer_q     <= buzzer_d;
      lamp_q       <= lamp_d;
    end
  end

  `RRIT_ASSERT_NXT(a_power_off_clears, step_i && !item_i.power_on,
                   !awake_q && in_lead_q && (elapsed_q == '0))
  `RRIT_ASSERT_IMP(a_asleep_is_quiet, !awake_q,
                   (elapsed_q == '0) && (lamp_q == LAMP_NONE) && !buzzer_q)
  `RRIT_ASSERT_NXT(a_no_step_holds, !step_i,
                   $stable(elapsed_q) && $stable(awake_q) && $stable(lamp_q))

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for round_rest_interval_timer: random and directed ticks,
// APB register settings, idling on both channels and a per-transaction output check.
// Depends on rrit_pkg and the timer RTL.
module tb_top;
  import rrit_pkg::*;

  localparam int HalfPeriod  = 5;
  localparam int ResetCycles = 9;
  localparam int IdlePct     = 29;
  localparam int HoldCycles  = 60;
  localparam int SettleCycles = 4;
  localparam int TimeLimit   = 4_000_000;
  localparam int CfgMask     = 32'h3FFFF;

  // Beep timing, ms
  localparam int GapMs       = 20;
  localparam int StartBeepMs = 500;
  localparam int WarnBeepMs  = 150;
  localparam int WarnPitchMs = 200;
  localparam int WarnBeeps   = 5;
  localparam int FinalOfsMs  = 1000;
  localparam int FinalBeepMs = 300;
  localparam int RestBeepMs  = 1500;

  // Tracks the timer state and holds the outputs still owed by the block
  class timer_tracker;
    int       regs [6];
    bit [18:0] elapsed;
    bit       lead_in;
    bit       awake;
    bit       last_round;
    bit       last_rest;
    bit       buzz;
    lamp_e    lamp;
    result_t  pending_outputs [$];
    int       errors;
    int       n_ticks;
    int       n_off;
    int       n_restarts;
    int       n_checked;
    int       n_buzz;
    int       n_orange;

    function new();
      regs[REG_LEAD_IN]     = 5000;
      regs[REG_SHORT_ROUND] = 120000;
      regs[REG_LONG_ROUND]  = 180000;
      regs[REG_SHORT_REST]  = 30000;
      regs[REG_LONG_REST]   = 60000;
      regs[REG_WARNING]     = 30000;
      clear_timer();
    endfunction

    function void clear_timer();
      elapsed    = '0;
      lead_in    = 1'b1;
      awake      = 1'b0;
      last_round = 1'b0;
      last_rest  = 1'b0;
      buzz       = 1'b0;
      lamp       = LAMP_NONE;
    endfunction

    function void restart_lead_in();
      lamp    = LAMP_NONE;
      buzz    = 1'b0;
      elapsed = '0;
      lead_in = 1'b1;
      n_restarts++;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      regs[idx] = data & CfgMask;
    endfunction

    // Sound for len-GapMs, then stay silent up to len; outside the window keep the latch
    function void sound(int len, int t, int start);
      if (t >= start && t <= start + len) begin
        buzz = (t >= start + len - GapMs) ? 1'b0 : 1'b1;
      end
    endfunction

    function void note_tick(logic pwr, logic rsel, logic ssel);
      int     t;
      int     r;
      int     s;
      int     w;
      int     k;
      phase_e ph;
      n_ticks++;
      if (!pwr) begin
        clear_timer();
        n_off++;
        pending_outputs.push_back(result_t'{1'b0, LAMP_NONE, 1'b0, PHASE_OFF, 19'd0});
        return;
      end
      // Capture the selectors on wake-up without a restart
      if (!awake) begin
        awake      = 1'b1;
        last_round = rsel;
        last_rest  = ssel;
      end
      if (rsel != last_round) begin
        last_round = rsel;
        restart_lead_in();
      end
      if (ssel != last_rest) begin
        last_rest = ssel;
        restart_lead_in();
      end
      r = rsel ? regs[REG_LONG_ROUND] : regs[REG_SHORT_ROUND];
      s = ssel ? regs[REG_LONG_REST] : regs[REG_SHORT_REST];
      w = regs[REG_WARNING];
      t = elapsed;
      if (lead_in) begin
        ph = PHASE_LEAD_IN;
        if (t <= regs[REG_LEAD_IN]) lamp = LAMP_RED;
        if (t >= regs[REG_LEAD_IN]) begin
          lead_in = 1'b0;
          elapsed = '0;
        end else begin
          elapsed = 19'(t + 1);
        end
      end else begin
        ph = PHASE_CYCLE;
        if (t <= r) begin
          if (w <= r && t >= r - w) begin
            for (k = 0; k < WarnBeeps; k++) sound(WarnBeepMs, t, r - w + WarnPitchMs * k);
            sound(FinalBeepMs, t, r - w + FinalOfsMs);
            lamp = LAMP_ORANGE;
          end else begin
            sound(StartBeepMs, t, 0);
            lamp = LAMP_GREEN;
          end
        end
        // The rest is applied last, so it wins at the round boundary
        if (t >= r && t <= r + s) begin
          sound(RestBeepMs, t, r);
          lamp = LAMP_RED;
        end
        if (t >= r + s) elapsed = '0;
        else elapsed = 19'(t + 1);
      end
      pending_outputs.push_back(result_t'{buzz, lamp, 1'b1, ph, 19'(t)});
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_outputs.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing expected, actual %p", $time, got);
        return;
      end
      want = pending_outputs.pop_front();
      n_checked++;
      if (want.buzzer) n_buzz++;
      if (want.lamp == LAMP_ORANGE) n_orange++;
      compare_field("buzzer", want.buzzer, got.buzzer);
      compare_field("lamp", want.lamp, got.lamp);
      compare_field("power_led", want.power_led, got.power_led);
      compare_field("phase", want.phase, got.phase);
      compare_field("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction
  endclass

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             psel         = 1'b0;
  logic             penable      = 1'b0;
  logic             pwrite       = 1'b0;
  logic [AddrW-1:0] paddr        = '0;
  logic [DataW-1:0] pwdata       = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic             power_on_i   = 1'b0;
  logic             round_long_i = 1'b0;
  logic             rest_long_i  = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic             buzzer_o;
  logic [1:0]       lamp_o;
  logic             power_led_o;
  logic [1:0]       phase_o;
  logic [TimeW-1:0] elapsed_ms_o;

  timer_tracker tracker;
  bit           steady;
  bit           hold_off_req;
  int           settings_used;

  round_rest_interval_timer dut (.*);

  always #HalfPeriod clk_i = ~clk_i;

  // Offer one tick and hold it until the block takes it
  task automatic send_tick(logic pwr, logic rsel, logic ssel);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    power_on_i   <= pwr;
    round_long_i <= rsel;
    rest_long_i  <= ssel;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_tick(pwr, rsel, ssel);
  endtask

  // Drop valid and wait until every owed result transaction has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] data);
    for (int i = REG_LEAD_IN; i <= REG_WARNING; i++) write_reg(3'(i), data);
    settings_used++;
  endtask

  // Mostly short lengths so whole cycles pass, now and then an extreme
  task automatic write_random_regs();
    int hi;
    int val;
    int roll;
    for (int i = REG_LEAD_IN; i <= REG_WARNING; i++) begin
      case (3'(i)) inside
        REG_LEAD_IN:                   hi = 30;
        REG_SHORT_ROUND, REG_LONG_ROUND: hi = 700;
        REG_SHORT_REST, REG_LONG_REST: hi = 150;
        default:                       hi = 600;
      endcase
      roll = $urandom_range(9);
      if (roll == 0) val = 0;
      else if (roll == 1) val = CfgMask;
      else val = $urandom_range(hi);
      write_reg(3'(i), {14'($urandom()), 18'(val)});
    end
    settings_used++;
  endtask

  // Well-formed powered runs, with selector flips and power drops as noise
  task automatic run_ticks(int n, int noise, int steady_ticks);
    logic rsel;
    logic ssel;
    int   roll;
    rsel = 1'($urandom_range(1));
    ssel = 1'($urandom_range(1));
    for (int k = 0; k < n; k++) begin
      steady = (k < steady_ticks);
      roll   = $urandom_range(999);
      if (roll < noise) begin
        if ($urandom_range(3) == 0) begin
          rsel = !rsel;
          ssel = !ssel;
        end else if ($urandom_range(1)) rsel = !rsel;
        else ssel = !ssel;
        send_tick(1'b1, rsel, ssel);
      end else if (roll < 2 * noise) begin
        send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
        rsel = 1'($urandom_range(1));
        ssel = 1'($urandom_range(1));
      end else begin
        send_tick(1'b1, rsel, ssel);
      end
    end
    steady = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < IdlePct);
      end
    end
  end

  // Check every result transaction against the oldest owed output
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_result(result_t'{buzzer_o, lamp_e'(lamp_o), power_led_o,
                                     phase_e'(phase_o), elapsed_ms_o});
    end
  end

  initial begin : watchdog
    #(TimeLimit);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    tracker = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: power off, wake with selectors captured, lead-in restart
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    repeat (4) send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    drain();

    // Tiny lengths: lead-in end, round/rest boundary, cycle restart,
    // warning longer than the short round and equal to the long one
    write_reg(REG_LEAD_IN, 32'd2);
    write_reg(REG_SHORT_ROUND, 32'd3);
    write_reg(REG_LONG_ROUND, 32'd6);
    write_reg(REG_SHORT_REST, 32'd2);
    write_reg(REG_LONG_REST, 32'd4);
    write_reg(REG_WARNING, 32'd6);
    settings_used++;
    repeat (10) send_tick(1'b1, 1'b0, 1'b0);
    repeat (12) send_tick(1'b1, 1'b1, 1'b0);
    repeat (2) send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    drain();

    // Extremes of every register
    write_all(32'h0);
    run_ticks(20, 20, 0);
    drain();
    write_all(32'hFFFF_FFFF);
    run_ticks(20, 20, 0);
    drain();

    // Warning over all of the short round: all five short beeps, the start of the final one,
    // then the handover to the rest; with the long round the same beeps after a green start
    write_reg(REG_LEAD_IN, 32'd1);
    write_reg(REG_SHORT_ROUND, 32'd1100);
    write_reg(REG_LONG_ROUND, 32'd1150);
    write_reg(REG_SHORT_REST, 32'd20);
    write_reg(REG_LONG_REST, 32'd30);
    write_reg(REG_WARNING, 32'd1100);
    settings_used++;
    run_ticks(1106, 0, 400);
    drain();

    // Random settings; hold off the receiver once while ticks keep coming
    for (int p = 0; p < 3; p++) begin
      write_random_regs();
      if (p == 1) hold_off_req = 1'b1;
      run_ticks(40, 15, 0);
      drain();
    end

    $display("Ran %0d ticks over %0d register settings, %0d with power off, %0d restarts.",
             tracker.n_ticks, settings_used, tracker.n_off, tracker.n_restarts);
    $display("Checked %0d results: buzzer on in %0d, warning lamp in %0d.",
             tracker.n_checked, tracker.n_buzz, tracker.n_orange);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
